// ----- hdl/nru_pkg.sv -----
// ----------------------------------------------------------------------------
// nru_pkg
// Types and constants for the not-recently-used page replacement block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nru_pkg;

    localparam int PAGE_BITS = 16;
    localparam int CNT_BITS  = 32;
    localparam int CFG_BITS  = 4;

    localparam logic [CFG_BITS-1:0] CFG_FRAMES_RESET = 4'd8;

    localparam logic ACT_ACCESS = 1'b0;
    localparam logic ACT_SET    = 1'b1;

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [CNT_BITS-1:0]  count_t;
    typedef logic [1:0]           page_class_t;

    typedef struct packed {
        logic  action;
        page_t page_number;
        logic  modified;
        logic  referenced;
    } nru_req_t;

    typedef struct packed {
        logic        hit;
        logic        evicted_valid;
        page_t       evicted_page;
        page_class_t evicted_class;
        logic        not_resident;
        count_t      hit_count;
        count_t      miss_count;
    } nru_rsp_t;

endpackage

`default_nettype wire

// ----- hdl/nru_page_replacement.sv -----
// ----------------------------------------------------------------------------
// nru_page_replacement
// Fully associative frame table with not-recently-used victim selection.
// ----------------------------------------------------------------------------
//  channel   | signals                   | transaction
//  ----------+---------------------------+-----------------------------------
//  request   | start, busy, req          | start high while busy low
//  response  | done, rsp                 | done high for one cycle
//  config    | cfg_we, cfg_wdata         | cfg_we high, frame limit written
//
//  One transaction per cycle; the result passes through the request register,
//  then table search, victim pick and rank update into the result register.
//  busy is always low.
//  Reset empties the table, clears both counters and sets the limit to 8.
//  The receiver cannot stall; every result is strobed exactly once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nru_page_replacement
    import nru_pkg::*;
#(
    parameter int FRAMES = 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire nru_req_t            req,
    output logic                     done,
    output nru_rsp_t                 rsp,
    input  wire logic                cfg_we,
    input  wire logic [CFG_BITS-1:0] cfg_wdata
);

    localparam int RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);

    logic [CFG_BITS-1:0] frames_in_use_reg;
    logic                req_valid_reg;
    nru_req_t            req_reg;
    logic                done_reg;
    nru_rsp_t            rsp_reg;
    nru_rsp_t            rsp_next;
    count_t              hits_reg;
    count_t              hits_next;
    count_t              misses_reg;
    count_t              misses_next;

    logic                valid_reg [FRAMES];
    logic                valid_next [FRAMES];
    page_t               page_reg [FRAMES];
    page_t               page_next [FRAMES];
    logic                mod_reg [FRAMES];
    logic                mod_next [FRAMES];
    logic                ref_reg [FRAMES];
    logic                ref_next [FRAMES];
    logic [RW-1:0]       rank_reg [FRAMES];
    logic [RW-1:0]       rank_next [FRAMES];

    logic [RW+1:0]       key [FRAMES];
    logic [FRAMES-1:0]   hit_vec;
    logic [FRAMES-1:0]   vic_vec;
    logic [FRAMES-1:0]   free_vec;
    logic [FRAMES-1:0]   unlink_vec;
    logic [FRAMES-1:0]   slot_vec;
    logic [CW-1:0]       valid_count;
    logic                hit_any;
    logic                full;
    logic                do_access;
    logic                do_set;
    logic                miss;
    logic                evict;
    logic [RW-1:0]       unlink_rank;
    logic [RW-1:0]       new_rank;
    page_t               ev_page;
    page_class_t         ev_class;

    assign busy = 1'b0;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    always_comb
    begin
        valid_count = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            hit_vec[i]  = valid_reg[i] && (page_reg[i] == req_reg.page_number);
            key[i]      = {ref_reg[i], mod_reg[i], ~rank_reg[i]};
            valid_count = valid_count + CW'(valid_reg[i]);
        end
    end

    // victim: lowest class, newest within it
    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            vic_vec[i] = valid_reg[i];
            for (int j = 0; j < FRAMES; j++)
            begin
                if (j != i && valid_reg[j] && !(key[j] > key[i]))
                begin
                    vic_vec[i] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        logic found;
        found = 1'b0;
        for (int i = 0; i < FRAMES; i++)
        begin
            free_vec[i] = !valid_reg[i] && !found;
            if (!valid_reg[i])
            begin
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (frames_in_use_reg == '0)
        begin
            full = (valid_count != '0);
        end
        else if (32'(frames_in_use_reg) > 32'(FRAMES))
        begin
            full = (32'(valid_count) >= 32'(FRAMES));
        end
        else
        begin
            full = (32'(valid_count) >= 32'(frames_in_use_reg));
        end
    end

    always_comb
    begin
        hit_any   = |hit_vec;
        do_access = req_valid_reg && (req_reg.action == ACT_ACCESS);
        do_set    = req_valid_reg && (req_reg.action == ACT_SET);
        miss      = do_access && !hit_any;
        evict     = miss && full;

        if (evict)
        begin
            unlink_vec = vic_vec;
            slot_vec   = vic_vec;
        end
        else if (miss)
        begin
            unlink_vec = '0;
            slot_vec   = free_vec;
        end
        else if (do_set && hit_any)
        begin
            unlink_vec = hit_vec;
            slot_vec   = hit_vec;
        end
        else
        begin
            unlink_vec = '0;
            slot_vec   = '0;
        end

        unlink_rank = '0;
        ev_page     = '0;
        ev_class    = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            unlink_rank = unlink_rank | (rank_reg[i] & {RW{unlink_vec[i]}});
            ev_page     = ev_page | (page_reg[i] & {PAGE_BITS{vic_vec[i]}});
            ev_class    = ev_class | ({ref_reg[i], mod_reg[i]} & {2{vic_vec[i]}});
        end

        if (|unlink_vec)
        begin
            new_rank = RW'(valid_count - CW'(1));
        end
        else
        begin
            new_rank = RW'(valid_count);
        end

        for (int i = 0; i < FRAMES; i++)
        begin
            valid_next[i] = valid_reg[i];
            page_next[i]  = page_reg[i];
            mod_next[i]   = mod_reg[i];
            ref_next[i]   = ref_reg[i];
            rank_next[i]  = rank_reg[i];
            if (valid_reg[i] && !unlink_vec[i] && (|unlink_vec) && rank_reg[i] > unlink_rank)
            begin
                rank_next[i] = rank_reg[i] - RW'(1);
            end
            if (slot_vec[i])
            begin
                valid_next[i] = 1'b1;
                page_next[i]  = req_reg.page_number;
                mod_next[i]   = do_set && req_reg.modified;
                ref_next[i]   = do_set && req_reg.referenced;
                rank_next[i]  = new_rank;
            end
        end

        hits_next   = hits_reg;
        misses_next = misses_reg;
        if (do_access && hit_any && hits_reg != '1)
        begin
            hits_next = hits_reg + count_t'(1);
        end
        if (miss && misses_reg != '1)
        begin
            misses_next = misses_reg + count_t'(1);
        end

        rsp_next.hit           = req_valid_reg && hit_any;
        rsp_next.evicted_valid = evict;
        rsp_next.evicted_page  = evict ? ev_page : '0;
        rsp_next.evicted_class = evict ? ev_class : '0;
        rsp_next.not_resident  = do_set && !hit_any;
        rsp_next.hit_count     = hits_next;
        rsp_next.miss_count    = misses_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= CFG_FRAMES_RESET;
            req_valid_reg     <= 1'b0;
            done_reg          <= 1'b0;
            hits_reg          <= '0;
            misses_reg        <= '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                valid_reg[i] <= 1'b0;
                mod_reg[i]   <= 1'b0;
                ref_reg[i]   <= 1'b0;
                rank_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                frames_in_use_reg <= cfg_wdata;
            end
            req_valid_reg <= start && !busy;
            done_reg      <= req_valid_reg;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            for (int i = 0; i < FRAMES; i++)
            begin
                valid_reg[i] <= valid_next[i];
                mod_reg[i]   <= mod_next[i];
                ref_reg[i]   <= ref_next[i];
                rank_reg[i]  <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req;
        end
        if (req_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
        for (int i = 0; i < FRAMES; i++)
        begin
            page_reg[i] <= page_next[i];
        end
    end

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted transaction produced no result");

    a_unique_pages: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg |-> $onehot0(hit_vec))
        else $error("page resident in more than one frame");

    a_single_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && full) |-> $onehot(vic_vec))
        else $error("victim pick not unique");

    a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(rsp.hit && rsp.evicted_valid) && !(rsp.hit && rsp.not_resident))
        else $error("inconsistent result flags");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for nru_page_replacement. A directed part covers
// table fill, hits, victim choice and the frame limit extremes. Random phases
// then run with a range of frame limits, over a small page pool so that
// evictions happen often. An in-bench model of the frame table predicts every
// response, and each response is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import nru_pkg::*;

    localparam int FRAMES    = 8;
    localparam int POOL_SIZE = 12;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                start     = 1'b0;
    logic                busy;
    nru_req_t            req       = '0;
    logic                done;
    nru_rsp_t            rsp;
    logic                cfg_we    = 1'b0;
    logic [CFG_BITS-1:0] cfg_wdata = '0;

    // frame table model
    logic                frame_used [FRAMES];
    page_t               frame_tag  [FRAMES];
    logic                frame_mod  [FRAMES];
    logic                frame_ref  [FRAMES];
    logic [2:0]          frame_age  [FRAMES];
    count_t              hits_seen;
    count_t              misses_seen;
    logic [CFG_BITS-1:0] frame_limit;

    nru_rsp_t expected_rsp [$];
    page_t    page_pool [POOL_SIZE];

    int n_sent        = 0;
    int n_checked     = 0;
    int n_evictions   = 0;
    int n_absent_sets = 0;
    int n_errors      = 0;

    nru_page_replacement #(.FRAMES(FRAMES)) u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("nru_page_replacement regression: fail");
        $finish;
    end

    function automatic int resident_count();
        int n;
        n = 0;
        for (int i = 0; i < FRAMES; i++)
            if (frame_used[i])
                n++;
        return n;
    endfunction

    function automatic void drop_frame(int k);
        frame_used[k] = 1'b0;
        for (int j = 0; j < FRAMES; j++)
            if (frame_used[j] && frame_age[j] > frame_age[k])
                frame_age[j] = frame_age[j] - 3'd1;
    endfunction

    function automatic void load_frame(int k, page_t pg, logic m, logic r);
        frame_age[k]  = 3'(resident_count());
        frame_tag[k]  = pg;
        frame_mod[k]  = m;
        frame_ref[k]  = r;
        frame_used[k] = 1'b1;
    endfunction

    function automatic void reset_table();
        for (int i = 0; i < FRAMES; i++)
        begin
            frame_used[i] = 1'b0;
            frame_tag[i]  = '0;
            frame_mod[i]  = 1'b0;
            frame_ref[i]  = 1'b0;
            frame_age[i]  = '0;
        end
        hits_seen   = '0;
        misses_seen = '0;
        frame_limit = CFG_FRAMES_RESET;
    endfunction

    // Works out the response to one request and updates the table model.
    function automatic nru_rsp_t nru_predict(nru_req_t r);
        nru_rsp_t    e;
        int          k;
        int          slot;
        int          lim;
        int          best_cls;
        logic [2:0]  best_age;
        int          cls;
        e   = '0;
        k   = -1;
        lim = (frame_limit == 0) ? 1 : (frame_limit > FRAMES) ? FRAMES : frame_limit;
        for (int i = FRAMES - 1; i >= 0; i--)
            if (frame_used[i] && frame_tag[i] == r.page_number)
                k = i;
        if (r.action == ACT_ACCESS)
        begin
            if (k >= 0)
            begin
                e.hit = 1'b1;
                if (hits_seen != '1)
                    hits_seen++;
            end
            else
            begin
                slot = -1;
                if (misses_seen != '1)
                    misses_seen++;
                if (resident_count() >= lim)
                begin
                    best_cls = 4;
                    best_age = '0;
                    for (int i = 0; i < FRAMES; i++)
                    begin
                        if (!frame_used[i])
                            continue;
                        cls = {frame_ref[i], frame_mod[i]};
                        if (cls < best_cls || (cls == best_cls && frame_age[i] > best_age))
                        begin
                            best_cls = cls;
                            best_age = frame_age[i];
                            slot     = i;
                        end
                    end
                    if (slot >= 0)
                    begin
                        e.evicted_valid = 1'b1;
                        e.evicted_page  = frame_tag[slot];
                        e.evicted_class = page_class_t'(best_cls);
                        drop_frame(slot);
                    end
                end
                if (slot < 0)
                    for (int i = FRAMES - 1; i >= 0; i--)
                        if (!frame_used[i])
                            slot = i;
                if (slot >= 0)
                    load_frame(slot, r.page_number, 1'b0, 1'b0);
            end
        end
        else if (k >= 0)
        begin
            e.hit = 1'b1;
            drop_frame(k);
            load_frame(k, r.page_number, r.modified, r.referenced);
        end
        else
            e.not_resident = 1'b1;
        e.hit_count  = hits_seen;
        e.miss_count = misses_seen;
        return e;
    endfunction

    function automatic void queue_expected(nru_rsp_t e);
        expected_rsp = {expected_rsp, e};
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        nru_rsp_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("response strobed with no transaction outstanding");
                n_errors++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                compare_field("hit", 32'(want.hit), 32'(rsp.hit));
                compare_field("evicted_valid", 32'(want.evicted_valid),
                              32'(rsp.evicted_valid));
                compare_field("evicted_page", 32'(want.evicted_page),
                              32'(rsp.evicted_page));
                compare_field("evicted_class", 32'(want.evicted_class),
                              32'(rsp.evicted_class));
                compare_field("not_resident", 32'(want.not_resident),
                              32'(rsp.not_resident));
                compare_field("hit_count", want.hit_count, rsp.hit_count);
                compare_field("miss_count", want.miss_count, rsp.miss_count);
                n_checked++;
                if (want.evicted_valid)
                    n_evictions++;
                if (want.not_resident)
                    n_absent_sets++;
            end
        end
    end

    function automatic nru_req_t make_req(logic act, page_t pg, logic m, logic r);
        nru_req_t q;
        q.action      = act;
        q.page_number = pg;
        q.modified    = m;
        q.referenced  = r;
        return q;
    endfunction

    function automatic int idle_gap(bit burst);
        int roll;
        if (burst)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 24);
    endfunction

    task automatic send_request(input nru_req_t r, input int gap);
        @(negedge clk);
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        queue_expected(nru_predict(r));
        n_sent++;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic access_page(input page_t pg);
        send_request(make_req(ACT_ACCESS, pg, 1'b0, 1'b0), idle_gap(1'b0));
    endtask

    task automatic set_page_bits(input page_t pg, input logic m, input logic r);
        send_request(make_req(ACT_SET, pg, m, r), idle_gap(1'b0));
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        start <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_frame_limit(input logic [CFG_BITS-1:0] value);
        drain_pipeline();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        frame_limit = value;
    endtask

    task automatic test_fill_and_hit();
        access_page(16'h0000);
        access_page(16'hFFFF);
        access_page(16'h1234);
        access_page(16'h8001);
        access_page(16'h0000);
        set_page_bits(16'hFFFF, 1'b1, 1'b1);
        set_page_bits(16'h1234, 1'b1, 1'b0);
        set_page_bits(16'h4321, 1'b1, 1'b1);
        access_page(16'h1234);
    endtask

    // Fills the table, then misses with class 0, 1 and 3 pages resident as candidates.
    task automatic test_victim_choice();
        access_page(16'hA5A5);
        access_page(16'h5A5A);
        access_page(16'h00FF);
        access_page(16'hFF00);
        access_page(16'h7777);
    endtask

    task automatic test_limit_extremes();
        write_frame_limit(4'd1);
        access_page(16'h0101);
        access_page(16'h0202);
        write_frame_limit(4'd0);
        access_page(16'h0303);
        write_frame_limit(4'hF);
        access_page(16'h0404);
        access_page(16'h0404);
    endtask

    task automatic test_random_phases();
        logic [CFG_BITS-1:0] limits [11] = '{4'd8, 4'd1, 4'd0, 4'hF, 4'd3, 4'd2,
                                             4'd5, 4'd9, 4'd7, 4'd4, 4'd6};
        nru_req_t r;
        bit       burst;
        burst = 1'b0;
        foreach (limits[p])
        begin
            write_frame_limit(limits[p]);
            foreach (page_pool[i])
                page_pool[i] = page_t'($urandom_range(0, 65535));
            for (int n = 0; n < 165; n++)
            begin
                if (n % 40 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                r.action      = ($urandom_range(0, 99) < 35) ? ACT_SET : ACT_ACCESS;
                r.page_number = ($urandom_range(0, 99) < 85)
                              ? page_pool[$urandom_range(0, POOL_SIZE - 1)]
                              : page_t'($urandom_range(0, 65535));
                r.modified    = 1'($urandom_range(0, 1));
                r.referenced  = 1'($urandom_range(0, 1));
                send_request(r, idle_gap(burst));
            end
        end
    endtask

    initial
    begin
        reset_table();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_fill_and_hit();
        test_victim_choice();
        test_limit_extremes();
        test_random_phases();
        drain_pipeline();

        $display("%0d requests sent, %0d responses checked over frame limits 0 to 15",
                 n_sent, n_checked);
        $display("%0d evictions, %0d set transactions on absent pages, %0d hits",
                 n_evictions, n_absent_sets, hits_seen);
        if (n_errors == 0)
            $display("nru_page_replacement regression: pass");
        else
            $display("nru_page_replacement regression: fail");
        $finish;
    end

endmodule
